// ----- src/dpc_pkg.sv -----
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types, codes and constants of the dictionary packed column engine.
// ----------------------------------------------------------------------------
package dpc_pkg;

   localparam int STORE_WORDS_DEFAULT   = 64;
   localparam int MAX_CODE_BITS_DEFAULT = 12;
   localparam logic [12:0] COUNT_CAP    = 13'd4096;

   // request actions
   localparam logic [2:0] ACT_LOAD = 3'd0;
   localparam logic [2:0] ACT_GET  = 3'd1;
   localparam logic [2:0] ACT_SET  = 3'd2;
   localparam logic [2:0] ACT_SUM  = 3'd3;
   localparam logic [2:0] ACT_FIND = 3'd4;

   // find conditions
   localparam logic [1:0] COND_EQ = 2'd0;
   localparam logic [1:0] COND_NE = 2'd1;
   localparam logic [1:0] COND_LT = 2'd2;
   localparam logic [1:0] COND_GT = 2'd3;

   // configuration register indexes
   localparam logic [2:0] REG_VALUE_WIDTH = 3'd0;
   localparam logic [2:0] REG_INDEX_WIDTH = 3'd1;
   localparam logic [2:0] REG_VALUE_COUNT = 3'd2;
   localparam logic [2:0] REG_INDEX_COUNT = 3'd3;
   localparam logic [2:0] REG_LOWER_BOUND = 3'd4;
   localparam logic [2:0] REG_UPPER_BOUND = 3'd5;

   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_MATCH = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   // scan modes of a find
   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_ALL,
      MODE_EQ,
      MODE_NE,
      MODE_LT,
      MODE_GE,
      MODE_SEARCH
   } mode_type;

   // datapath commands
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LOAD,
      OP_ADDR_CODE,
      OP_ADDR_VAL,
      OP_ADDR_DICT,
      OP_RD0,
      OP_RD1,
      OP_EXT_CODE,
      OP_EXT_VAL,
      OP_MERGE,
      OP_WR0,
      OP_WR1,
      OP_ACCUM,
      OP_SKIP,
      OP_CLASSIFY,
      OP_DICT_NEXT,
      OP_BOUND,
      OP_EMIT_ACK,
      OP_EMIT_VALUE,
      OP_EMIT_SUM,
      OP_EMIT_NF,
      OP_EMIT_MATCH,
      OP_EMIT_DONE
   } op_type;

   typedef struct packed {
      logic [2:0] action;
      logic       pos_lt_ic;
      logic       load_ok;
      logic       i_done;
      logic       n_full;
      mode_type   mode;
      logic       dict_end;
      logic       dict_hit;
      logic       code_hit;
      logic       out_free;
   } status_type;

endpackage

// ----- src/dictionary_packed_column_engine.sv -----
// ----------------------------------------------------------------------------
// dictionary_packed_column_engine
// Bit-packed dictionary column store with load, get, set, sum and find.
// ----------------------------------------------------------------------------
// One request is worked at a time. Every packed field read takes the steps
// address, two store word reads through the single registered memory port,
// and extract. Each result needs a free output register; a stalled result
// holds the sequencer. The packed store has no reset and must be loaded
// before it is read.
// ----------------------------------------------------------------------------
module dictionary_packed_column_engine
   import dpc_pkg::*;
#(
   parameter int STORE_WORDS   = STORE_WORDS_DEFAULT,
   parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic [11:0]        req_position,
   input  logic [12:0]        req_range_end,
   input  logic [63:0]        req_raw_word,
   input  logic signed [63:0] req_key_value,
   input  logic [1:0]         req_condition,
   input  logic [31:0]        req_base_index,
   input  logic [5:0]         req_match_limit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [63:0] rsp_result_value,
   output logic [32:0]        rsp_match_index,
   output logic               rsp_last
);

   op_type     op;
   status_type status;

   dpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   dpc_datapath #(
      .STORE_WORDS   (STORE_WORDS),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_action       (req_action),
      .req_position     (req_position),
      .req_range_end    (req_range_end),
      .req_raw_word     (req_raw_word),
      .req_key_value    (req_key_value),
      .req_condition    (req_condition),
      .req_base_index   (req_base_index),
      .req_match_limit  (req_match_limit),
      .op               (op),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_result_value (rsp_result_value),
      .rsp_match_index  (rsp_match_index),
      .rsp_last         (rsp_last)
   );

   // an accepted request always makes the engine busy
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine idle after accepting a request");

   // a match is never the final result of a request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_MATCH) |-> !rsp_last)
      else $error("match result flagged last");

   // results are only loaded while the output register is free
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> (op != OP_EMIT_ACK && op != OP_EMIT_VALUE &&
         op != OP_EMIT_SUM && op != OP_EMIT_NF && op != OP_EMIT_MATCH &&
         op != OP_EMIT_DONE))
      else $error("result overwritten while stalled");

endmodule

// ----- src/dpc_datapath.sv -----
// ----------------------------------------------------------------------------
// dpc_datapath
// Configuration registers, packed store, field extract and merge, counters,
// comparators and the result register.
// ----------------------------------------------------------------------------
module dpc_datapath #(
   parameter int STORE_WORDS   = 64,
   parameter int MAX_CODE_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_data,
   input  logic [2:0]          req_action,
   input  logic [11:0]         req_position,
   input  logic [12:0]         req_range_end,
   input  logic [63:0]         req_raw_word,
   input  logic signed [63:0]  req_key_value,
   input  logic [1:0]          req_condition,
   input  logic [31:0]         req_base_index,
   input  logic [5:0]          req_match_limit,
   input  dpc_pkg::op_type     op,
   output dpc_pkg::status_type status,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [1:0]          rsp_kind,
   output logic signed [63:0]  rsp_result_value,
   output logic [32:0]         rsp_match_index,
   output logic                rsp_last
);
   import dpc_pkg::*;

   localparam int CODE_W = MAX_CODE_BITS;
   localparam int ADDR_W = ((CODE_W + 7 > 20) ? CODE_W + 7 : 20) + 1;
   localparam int WI_W   = ADDR_W - 6;
   localparam int SW_AW  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int CMP_W  = (CODE_W > 13) ? CODE_W : 13;

   // configuration
   logic [6:0]         vw_ff;
   logic [3:0]         iw_ff;
   logic [12:0]        vc_ff, ic_ff;
   logic signed [63:0] lo_ff, hi_ff;

   // request and work registers
   logic [2:0]          act_ff;
   logic [11:0]         pos_ff;
   logic [12:0]         end_ff;
   logic [63:0]         raw_ff;
   logic signed [63:0]  key_ff;
   logic [1:0]          cond_ff;
   logic [31:0]         base_ff;
   logic [5:0]          limit_ff;
   logic [12:0]         i_ff, j_ff;
   logic [5:0]          n_ff;
   logic [63:0]         acc_ff;
   logic [CODE_W-1:0]   code_ff;
   logic signed [63:0]  val_ff;
   mode_type            mode_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [63:0]         w0_ff, w1_ff, rd_ff;

   // result register
   logic                rsp_valid_ff;
   logic [1:0]          kind_ff;
   logic signed [63:0]  value_ff;
   logic [32:0]         index_ff;
   logic                last_ff;

   logic [63:0]         mem [STORE_WORDS];

   logic [6:0]          vw_eff;
   logic [5:0]          iw_eff;
   logic [12:0]         vc_eff, ic_eff, end_clip;
   logic [19:0]         dict_bits;
   logic [18:0]         code_off;
   logic [WI_W-1:0]     idx0;
   logic [WI_W:0]       idx1;
   logic [5:0]          sh;
   logic                ok0, ok1, i_done;
   logic [127:0]        win, sh_win, fmask, fdata, merged;
   logic [63:0]         cmask, vmask, vbits, vsign, code_bits;
   logic signed [63:0]  vsext;
   logic                can, will, dict_hit, code_hit, out_free;
   mode_type            class_mode, bound_mode;
   logic [CMP_W-1:0]    cmp_c, cmp_b;
   logic [SW_AW-1:0]    rd_idx;

   // effective widths and counts
   always_comb begin
      if (vw_ff == 7'd0) begin
         vw_eff = 7'd1;
      end else if (vw_ff > 7'd64) begin
         vw_eff = 7'd64;
      end else begin
         vw_eff = vw_ff;
      end
      if (iw_ff == 4'd0) begin
         iw_eff = 6'd1;
      end else if (6'(iw_ff) > 6'(MAX_CODE_BITS)) begin
         iw_eff = 6'(MAX_CODE_BITS);
      end else begin
         iw_eff = 6'(iw_ff);
      end
      vc_eff   = (vc_ff > COUNT_CAP) ? COUNT_CAP : vc_ff;
      ic_eff   = (ic_ff > COUNT_CAP) ? COUNT_CAP : ic_ff;
      end_clip = (req_range_end > ic_eff) ? ic_eff : req_range_end;
   end

   // bit addresses and word window
   assign dict_bits = 20'(vc_eff) * 20'(vw_eff);
   assign code_off  = 19'(i_ff) * 19'(iw_eff);
   assign idx0      = addr_ff[ADDR_W-1:6];
   assign idx1      = {1'b0, idx0} + (WI_W+1)'(1);
   assign sh        = addr_ff[5:0];
   assign ok0       = {1'b0, idx0} < (WI_W+1)'(STORE_WORDS);
   assign ok1       = idx1 < (WI_W+1)'(STORE_WORDS);

   // extract and merge a field; words past the store read as zero
   always_comb begin
      win       = {ok1 ? rd_ff : 64'd0, ok0 ? w0_ff : 64'd0};
      sh_win    = win >> sh;
      cmask     = (64'd1 << iw_eff) - 64'd1;
      vmask     = (vw_eff == 7'd64) ? {64{1'b1}} : ((64'd1 << vw_eff) - 64'd1);
      code_bits = sh_win[63:0] & cmask;
      vbits     = sh_win[63:0] & vmask;
      vsign     = 64'd1 << (vw_eff - 7'd1);
      vsext     = signed'((vbits ^ vsign) - vsign);
      fmask     = {64'd0, vmask} << sh;
      fdata     = {64'd0, key_ff & vmask} << sh;
      merged    = ({rd_ff, w0_ff} & ~fmask) | fdata;
   end

   // find classification against the bounds
   always_comb begin
      case (cond_ff)
         COND_EQ: begin
            can  = (lo_ff <= key_ff) && (key_ff <= hi_ff);
            will = (key_ff == lo_ff) && (key_ff == hi_ff);
         end
         COND_NE: begin
            can  = !((key_ff == lo_ff) && (key_ff == hi_ff));
            will = (key_ff > hi_ff) || (key_ff < lo_ff);
         end
         COND_LT: begin
            can  = lo_ff < key_ff;
            will = hi_ff < key_ff;
         end
         default: begin
            can  = hi_ff > key_ff;
            will = lo_ff > key_ff;
         end
      endcase
      if (!can) begin
         class_mode = MODE_NONE;
      end else if (will) begin
         class_mode = MODE_ALL;
      end else begin
         class_mode = MODE_SEARCH;
      end
      case (cond_ff)
         COND_EQ: bound_mode = (j_ff >= vc_eff) ? MODE_NONE : MODE_EQ;
         COND_NE: bound_mode = (j_ff >= vc_eff) ? MODE_ALL : MODE_NE;
         COND_LT: bound_mode = MODE_LT;
         default: bound_mode = (j_ff >= vc_eff) ? MODE_NONE : MODE_GE;
      endcase
      case (cond_ff)
         COND_EQ, COND_NE: dict_hit = val_ff == key_ff;
         COND_LT:          dict_hit = val_ff >= key_ff;
         default:          dict_hit = val_ff > key_ff;
      endcase
      cmp_c = CMP_W'(code_ff);
      cmp_b = CMP_W'(j_ff);
      case (mode_ff)
         MODE_ALL: code_hit = 1'b1;
         MODE_EQ:  code_hit = cmp_c == cmp_b;
         MODE_NE:  code_hit = cmp_c != cmp_b;
         MODE_LT:  code_hit = cmp_c < cmp_b;
         MODE_GE:  code_hit = cmp_c >= cmp_b;
         default:  code_hit = 1'b0;
      endcase
   end

   assign i_done   = i_ff >= end_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status.action    = act_ff;
      status.pos_lt_ic = {1'b0, pos_ff} < ic_eff;
      status.load_ok   = {1'b0, pos_ff} < 13'(STORE_WORDS);
      status.i_done    = i_done;
      status.n_full    = n_ff >= limit_ff;
      status.mode      = mode_ff;
      status.dict_end  = j_ff >= vc_eff;
      status.dict_hit  = dict_hit;
      status.code_hit  = code_hit;
      status.out_free  = out_free;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vw_ff <= 7'd64;
         iw_ff <= 4'd1;
         vc_ff <= 13'd0;
         ic_ff <= 13'd0;
         lo_ff <= 64'sd0;
         hi_ff <= 64'sd0;
      end else if (csr_write) begin
         case (csr_index)
            REG_VALUE_WIDTH: vw_ff <= csr_data[6:0];
            REG_INDEX_WIDTH: iw_ff <= csr_data[3:0];
            REG_VALUE_COUNT: vc_ff <= csr_data[12:0];
            REG_INDEX_COUNT: ic_ff <= csr_data[12:0];
            REG_LOWER_BOUND: lo_ff <= signed'(csr_data);
            REG_UPPER_BOUND: hi_ff <= signed'(csr_data);
            default: ;
         endcase
      end
   end

   // packed store: one write and one registered read a cycle
   assign rd_idx = (op == OP_RD1) ? idx1[SW_AW-1:0] : idx0[SW_AW-1:0];

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_idx];
      if (op == OP_LOAD) begin
         mem[pos_ff[SW_AW-1:0]] <= raw_ff;
      end else if (op == OP_WR0 && ok0) begin
         mem[idx0[SW_AW-1:0]] <= w0_ff;
      end else if (op == OP_WR1 && ok1) begin
         mem[idx1[SW_AW-1:0]] <= w1_ff;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
      end else begin
         case (op)
            OP_CAPTURE: begin
               act_ff   <= req_action;
               pos_ff   <= req_position;
               end_ff   <= end_clip;
               raw_ff   <= req_raw_word;
               key_ff   <= req_key_value;
               cond_ff  <= req_condition;
               base_ff  <= req_base_index;
               limit_ff <= req_match_limit;
               i_ff     <= {1'b0, req_position};
               j_ff     <= 13'd0;
               n_ff     <= 6'd0;
               acc_ff   <= 64'd0;
               mode_ff  <= MODE_NONE;
            end
            OP_ADDR_CODE: addr_ff <= ADDR_W'(dict_bits) + ADDR_W'(code_off);
            OP_ADDR_VAL:  addr_ff <= ADDR_W'(code_ff) * ADDR_W'(vw_eff);
            OP_ADDR_DICT: addr_ff <= ADDR_W'(j_ff) * ADDR_W'(vw_eff);
            OP_RD1:       w0_ff   <= rd_ff;
            OP_EXT_CODE:  code_ff <= code_bits[CODE_W-1:0];
            OP_EXT_VAL:   val_ff  <= vsext;
            OP_MERGE: begin
               w0_ff <= merged[63:0];
               w1_ff <= merged[127:64];
            end
            OP_ACCUM: begin
               acc_ff <= acc_ff + val_ff;
               i_ff   <= i_ff + 13'd1;
            end
            OP_SKIP:      i_ff    <= i_ff + 13'd1;
            OP_CLASSIFY:  mode_ff <= class_mode;
            OP_DICT_NEXT: j_ff    <= j_ff + 13'd1;
            OP_BOUND:     mode_ff <= bound_mode;
            OP_EMIT_MATCH: begin
               i_ff <= i_ff + 13'd1;
               n_ff <= n_ff + 6'd1;
            end
            default: ;
         endcase
      end
   end

   // result register: load a new result, else drop an accepted one
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         case (op)
            OP_EMIT_ACK, OP_EMIT_VALUE, OP_EMIT_SUM, OP_EMIT_NF, OP_EMIT_MATCH,
            OP_EMIT_DONE: rsp_valid_ff <= 1'b1;
            default: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
         endcase
      end
      case (op)
         OP_EMIT_ACK: begin
            kind_ff  <= KIND_ACK;
            value_ff <= 64'sd0;
            index_ff <= 33'd0;
            last_ff  <= 1'b1;
         end
         OP_EMIT_VALUE: begin
            kind_ff  <= KIND_VALUE;
            value_ff <= val_ff;
            index_ff <= 33'd0;
            last_ff  <= 1'b1;
         end
         OP_EMIT_SUM: begin
            kind_ff  <= KIND_VALUE;
            value_ff <= signed'(acc_ff);
            index_ff <= 33'd0;
            last_ff  <= 1'b1;
         end
         OP_EMIT_NF: begin
            kind_ff  <= KIND_DONE;
            value_ff <= 64'sd0;
            index_ff <= 33'd0;
            last_ff  <= 1'b1;
         end
         OP_EMIT_MATCH: begin
            kind_ff  <= KIND_MATCH;
            value_ff <= 64'sd0;
            index_ff <= 33'(i_ff) + 33'(base_ff);
            last_ff  <= 1'b0;
         end
         OP_EMIT_DONE: begin
            kind_ff  <= KIND_DONE;
            value_ff <= (mode_ff == MODE_NONE || i_done) ? 64'(end_ff) : 64'(i_ff);
            index_ff <= 33'd0;
            last_ff  <= 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_result_value = value_ff;
   assign rsp_match_index  = index_ff;
   assign rsp_last         = last_ff;

endmodule

// ----- src/dpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// dpc_ctrl
// Sequencer: steps each request through field reads, writes, scans and
// result emission by issuing one datapath command a cycle, waiting in an emit step while the output is stalled.
// ----------------------------------------------------------------------------
module dpc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dpc_pkg::status_type status,
   output dpc_pkg::op_type     op
);
   import dpc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_LOAD, S_ADDR_CODE, S_ADDR_VAL, S_RD0, S_RD1, S_EXT,
      S_WR0, S_WR1, S_SUM_CHECK, S_ACCUM, S_CLASSIFY, S_CLASS_BR, S_DS_CHECK,
      S_DS_ADDR, S_DS_CMP, S_BOUND, S_SC_CHECK, S_SC_TEST, S_EMIT_ACK,
      S_EMIT_VALUE, S_EMIT_SUM, S_EMIT_NF, S_EMIT_MATCH, S_EMIT_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_CODE, PH_VAL, PH_SET
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   assign req_stall = state_ff != S_IDLE;

   // next state and command
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.action)
               ACT_LOAD: state_in = status.load_ok ? S_LOAD : S_EMIT_NF;
               ACT_GET, ACT_SET: state_in = status.pos_lt_ic ? S_ADDR_CODE : S_EMIT_NF;
               ACT_SUM:  state_in = S_SUM_CHECK;
               ACT_FIND: state_in = status.i_done ? S_EMIT_DONE : S_CLASSIFY;
               default:  state_in = S_EMIT_NF;
            endcase
         end
         S_LOAD: begin
            op       = OP_LOAD;
            state_in = S_EMIT_ACK;
         end
         S_ADDR_CODE: begin
            op       = OP_ADDR_CODE;
            phase_in = PH_CODE;
            state_in = S_RD0;
         end
         S_ADDR_VAL: begin
            op       = OP_ADDR_VAL;
            state_in = S_RD0;
         end
         S_RD0: begin
            op       = OP_RD0;
            state_in = S_RD1;
         end
         S_RD1: begin
            op       = OP_RD1;
            state_in = S_EXT;
         end
         S_EXT: begin
            case (phase_ff)
               PH_CODE: begin
                  op = OP_EXT_CODE;
                  if (status.action == ACT_FIND) begin
                     state_in = S_SC_TEST;
                  end else begin
                     phase_in = (status.action == ACT_SET) ? PH_SET : PH_VAL;
                     state_in = S_ADDR_VAL;
                  end
               end
               PH_VAL: begin
                  op = OP_EXT_VAL;
                  if (status.action == ACT_GET) begin
                     state_in = S_EMIT_VALUE;
                  end else if (status.action == ACT_SUM) begin
                     state_in = S_ACCUM;
                  end else begin
                     state_in = S_DS_CMP;
                  end
               end
               default: begin
                  op       = OP_MERGE;
                  state_in = S_WR0;
               end
            endcase
         end
         S_WR0: begin
            op       = OP_WR0;
            state_in = S_WR1;
         end
         S_WR1: begin
            op       = OP_WR1;
            state_in = S_EMIT_ACK;
         end
         S_SUM_CHECK: state_in = status.i_done ? S_EMIT_SUM : S_ADDR_CODE;
         S_ACCUM: begin
            op       = OP_ACCUM;
            state_in = S_SUM_CHECK;
         end
         S_CLASSIFY: begin
            op       = OP_CLASSIFY;
            state_in = S_CLASS_BR;
         end
         S_CLASS_BR: state_in = (status.mode == MODE_SEARCH) ? S_DS_CHECK : S_SC_CHECK;
         S_DS_CHECK: state_in = status.dict_end ? S_BOUND : S_DS_ADDR;
         S_DS_ADDR: begin
            op       = OP_ADDR_DICT;
            phase_in = PH_VAL;
            state_in = S_RD0;
         end
         S_DS_CMP: begin
            if (status.dict_hit) begin
               state_in = S_BOUND;
            end else begin
               op       = OP_DICT_NEXT;
               state_in = S_DS_CHECK;
            end
         end
         S_BOUND: begin
            op       = OP_BOUND;
            state_in = S_SC_CHECK;
         end
         S_SC_CHECK: begin
            if (status.i_done || status.n_full || status.mode == MODE_NONE) begin
               state_in = S_EMIT_DONE;
            end else if (status.mode == MODE_ALL) begin
               state_in = S_EMIT_MATCH;
            end else begin
               state_in = S_ADDR_CODE;
            end
         end
         S_SC_TEST: begin
            if (status.code_hit) begin
               state_in = S_EMIT_MATCH;
            end else begin
               op       = OP_SKIP;
               state_in = S_SC_CHECK;
            end
         end
         S_EMIT_MATCH: begin
            if (status.out_free) begin
               op       = OP_EMIT_MATCH;
               state_in = S_SC_CHECK;
            end
         end
         S_EMIT_ACK, S_EMIT_VALUE, S_EMIT_SUM, S_EMIT_NF, S_EMIT_DONE: begin
            if (status.out_free) begin
               case (state_ff)
                  S_EMIT_ACK:   op = OP_EMIT_ACK;
                  S_EMIT_VALUE: op = OP_EMIT_VALUE;
                  S_EMIT_SUM:   op = OP_EMIT_SUM;
                  S_EMIT_NF:    op = OP_EMIT_NF;
                  default:      op = OP_EMIT_DONE;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_CODE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule
